[rtl/merged_chroma_upsample_ycc_to_rgb_macros.svh]
// Assertion macros used by the top level of the merged chroma upsampler.
// Depends on nothing; the including module must have clk and arst_n.
`ifndef MERGED_CHROMA_UPSAMPLE_YCC_TO_RGB_MACROS_SVH
`define MERGED_CHROMA_UPSAMPLE_YCC_TO_RGB_MACROS_SVH

// Same-cycle implication, checked on clk, off while in reset.
`define MCU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mcu assertion failed");

// Implication after a fixed number of cycles.
`define MCU_ASSERT_DLY(lbl, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("mcu assertion failed");

`endif

[rtl/mcu_pkg.sv]
// Package for the merged chroma upsampler: payload structs, layout codes,
// fixed-point constants. No dependencies.
`timescale 1ns / 1ps

package mcu_pkg;

	// byte order codes of pixel_layout; 6 and 7 pack as rgb
	localparam logic [2:0] LAYOUT_RGB  = 3'd0;
	localparam logic [2:0] LAYOUT_BGR  = 3'd1;
	localparam logic [2:0] LAYOUT_RGBX = 3'd2;
	localparam logic [2:0] LAYOUT_XRGB = 3'd3;
	localparam logic [2:0] LAYOUT_BGRX = 3'd4;
	localparam logic [2:0] LAYOUT_XBGR = 3'd5;

	localparam logic [7:0] ALPHA_BYTE = 8'hFF;

	// Q16 chroma coefficients
	localparam logic signed [17:0] K_RED   = 18'sd91881;
	localparam logic signed [17:0] K_GR_CB = 18'sd22554;
	localparam logic signed [17:0] K_GR_CR = 18'sd46802;
	localparam logic signed [17:0] K_BLUE  = 18'sd116130;
	localparam logic signed [26:0] HALF_Q16 = 27'sd32768;

	localparam int PROD_W = 26;
	localparam int SUM_W  = 27;
	localparam int TERM_W = 10;

	typedef struct packed {
		logic [7:0] luma_even;
		logic [7:0] luma_odd;
		logic [7:0] chroma_blue;
		logic [7:0] chroma_red;
		logic       single;
	} item_t;

	typedef struct packed {
		logic [7:0] first_byte0;
		logic [7:0] first_byte1;
		logic [7:0] first_byte2;
		logic [7:0] first_byte3;
		logic [7:0] second_byte0;
		logic [7:0] second_byte1;
		logic [7:0] second_byte2;
		logic [7:0] second_byte3;
		logic [1:0] pixel_count;
	} result_t;

	// descaled chroma terms plus lumas, out of the term stages
	typedef struct packed {
		logic                     valid;
		logic                     single;
		logic [7:0]               luma_even;
		logic [7:0]               luma_odd;
		logic signed [TERM_W-1:0] term_r;
		logic signed [TERM_W-1:0] term_g;
		logic signed [TERM_W-1:0] term_b;
	} term_bus_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		logic valid;
		logic single;
		rgb_t px_even;
		rgb_t px_odd;
	} rgb_bus_t;

endpackage

[rtl/mcu_chroma_terms.sv]
// Chroma term stages 1 and 2: Q16 products, then round and descale.
// Depends on mcu_pkg.
`timescale 1ns / 1ps

module mcu_chroma_terms import mcu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  item_t     in_item,
	output term_bus_t terms
);

	logic signed [7:0]        cb_c, cr_c;
	logic                     valid_s1, valid_s2;
	logic signed [PROD_W-1:0] p_red_s1, p_gcb_s1, p_gcr_s1, p_blue_s1;
	item_t                    item_s1;
	logic signed [SUM_W-1:0]  sum_r, sum_g, sum_b;
	logic signed [TERM_W-1:0] term_r_s2, term_g_s2, term_b_s2;
	logic                     single_s2;
	logic [7:0]               ye_s2, yo_s2;

	// raw - 128 is the raw byte with its top bit flipped, read as signed
	assign cb_c = $signed({~in_item.chroma_blue[7], in_item.chroma_blue[6:0]});
	assign cr_c = $signed({~in_item.chroma_red[7], in_item.chroma_red[6:0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		item_s1   <= in_item;
		p_red_s1  <= PROD_W'(K_RED) * PROD_W'(cr_c);
		p_gcb_s1  <= PROD_W'(K_GR_CB) * PROD_W'(cb_c);
		p_gcr_s1  <= PROD_W'(K_GR_CR) * PROD_W'(cr_c);
		p_blue_s1 <= PROD_W'(K_BLUE) * PROD_W'(cb_c);
	end

	always_comb begin
		sum_r = SUM_W'(p_red_s1) + HALF_Q16;
		sum_g = HALF_Q16 - SUM_W'(p_gcb_s1) - SUM_W'(p_gcr_s1);
		sum_b = SUM_W'(p_blue_s1) + HALF_Q16;
	end

	// arithmetic shift by 16 = floor, matches the biased descale
	always_ff @(posedge clk) begin
		term_r_s2 <= sum_r[16 +: TERM_W];
		term_g_s2 <= sum_g[16 +: TERM_W];
		term_b_s2 <= sum_b[16 +: TERM_W];
		single_s2 <= item_s1.single;
		ye_s2     <= item_s1.luma_even;
		yo_s2     <= item_s1.luma_odd;
	end

	assign terms = '{valid: valid_s2, single: single_s2, luma_even: ye_s2,
		luma_odd: yo_s2, term_r: term_r_s2, term_g: term_g_s2, term_b: term_b_s2};

endmodule

[rtl/mcu_pixel_clamp.sv]
// Stage 3: adds the chroma terms to both lumas and clamps to 0..255.
// Depends on mcu_pkg.
`timescale 1ns / 1ps

module mcu_pixel_clamp import mcu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  term_bus_t terms,
	output rgb_bus_t  pixels
);

	logic valid_s3, single_s3;
	rgb_t even_s3, odd_s3;
	rgb_t even_c, odd_c;

	function automatic logic [7:0] add_clamp(input logic [7:0] y,
		input logic signed [TERM_W-1:0] t);
		logic signed [TERM_W-1:0] s;
		s = $signed({2'b00, y}) + t;
		if (s[TERM_W-1]) begin
			add_clamp = 8'd0;
		end else if (s[8]) begin
			add_clamp = 8'hFF;
		end else begin
			add_clamp = s[7:0];
		end
	endfunction

	always_comb begin
		even_c.r = add_clamp(terms.luma_even, terms.term_r);
		even_c.g = add_clamp(terms.luma_even, terms.term_g);
		even_c.b = add_clamp(terms.luma_even, terms.term_b);
		odd_c.r  = add_clamp(terms.luma_odd, terms.term_r);
		odd_c.g  = add_clamp(terms.luma_odd, terms.term_g);
		odd_c.b  = add_clamp(terms.luma_odd, terms.term_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= terms.valid;
		end
	end

	always_ff @(posedge clk) begin
		single_s3 <= terms.single;
		even_s3   <= even_c;
		odd_s3    <= odd_c;
	end

	assign pixels = '{valid: valid_s3, single: single_s3, px_even: even_s3,
		px_odd: odd_s3};

endmodule

[rtl/mcu_pack.sv]
// Stage 4: byte ordering of both pixels into the result register.
// Depends on mcu_pkg.
`timescale 1ns / 1ps

module mcu_pack import mcu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  rgb_bus_t   pixels,
	input  logic [2:0] layout,
	output logic       done,
	output result_t    result
);

	logic       valid_s4;
	result_t    result_s4;
	logic [31:0] even_w, odd_w;

	function automatic logic [31:0] pack_px(input rgb_t p, input logic [2:0] lay);
		logic [31:0] w;
		case (lay)
			LAYOUT_BGR:  w = {p.b, p.g, p.r, 8'd0};
			LAYOUT_RGBX: w = {p.r, p.g, p.b, ALPHA_BYTE};
			LAYOUT_XRGB: w = {ALPHA_BYTE, p.r, p.g, p.b};
			LAYOUT_BGRX: w = {p.b, p.g, p.r, ALPHA_BYTE};
			LAYOUT_XBGR: w = {ALPHA_BYTE, p.b, p.g, p.r};
			default:     w = {p.r, p.g, p.b, 8'd0};
		endcase
		pack_px = w;
	endfunction

	// word is {byte0, byte1, byte2, byte3}
	assign even_w = pack_px(pixels.px_even, layout);
	assign odd_w  = pixels.single ? 32'd0 : pack_px(pixels.px_odd, layout);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= pixels.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_s4.first_byte0  <= even_w[31:24];
		result_s4.first_byte1  <= even_w[23:16];
		result_s4.first_byte2  <= even_w[15:8];
		result_s4.first_byte3  <= even_w[7:0];
		result_s4.second_byte0 <= odd_w[31:24];
		result_s4.second_byte1 <= odd_w[23:16];
		result_s4.second_byte2 <= odd_w[15:8];
		result_s4.second_byte3 <= odd_w[7:0];
		result_s4.pixel_count  <= pixels.single ? 2'd1 : 2'd2;
	end

	assign done   = valid_s4;
	assign result = result_s4;

endmodule

[rtl/merged_chroma_upsample_ycc_to_rgb.sv]
// Top level of the merged h2v1 chroma upsampler and YCbCr-to-RGB converter.
// Depends on mcu_pkg, mcu_chroma_terms, mcu_pixel_clamp, mcu_pack and the macro header.
//
// Usage:
//  - Input: drive item and raise start; the transfer happens at the rising
//    edge where start is high and busy is low. busy is always low, so one
//    item (two lumas plus one Cb,Cr pair) can be taken every clock cycle.
//  - Output: done is high for exactly one cycle with result valid; the
//    transfer completes at the edge that ends that cycle. There is no
//    backpressure on this side; the receiver must take every result.
//  - Pipeline: an accepted item passes the product stage, descale stage,
//    add/clamp stage and byte-pack stage, then raises done. Throughput is
//    one item per cycle, set by the fully pipelined multiplier stage.
//  - Config: cfg_valid/cfg_ready/cfg_data write pixel_layout (cfg_ready is
//    always high). Change it only while no item is in flight; the layout
//    is sampled at the pack stage.
//  - Reset: arst_n low clears all stage valid bits and sets the layout to
//    rgb. Nothing in flight survives reset.
//  - Single-pixel items give pixel_count 1 and all second bytes zero.
`timescale 1ns / 1ps

`include "merged_chroma_upsample_ycc_to_rgb_macros.svh"

module merged_chroma_upsample_ycc_to_rgb import mcu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  mcu_pkg::item_t item,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_data,
	output logic         done,
	output mcu_pkg::result_t result
);

	logic      layout_q;
	logic [2:0] pixel_layout_q;
	logic      accept;
	term_bus_t terms;
	rgb_bus_t  pixels;

	// fully pipelined: never refuses an item
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_layout_q <= LAYOUT_RGB;
			layout_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				pixel_layout_q <= cfg_data;
			end
			// marks that a layout write has been seen since reset
			layout_q <= layout_q | (cfg_valid & cfg_ready);
		end
	end

	// stages 1-2: products, rounding and descale of the chroma terms
	mcu_chroma_terms u_terms (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.in_item  (item),
		.terms    (terms)
	);

	// stage 3: luma plus term, clamp
	mcu_pixel_clamp u_clamp (
		.clk    (clk),
		.arst_n (arst_n),
		.terms  (terms),
		.pixels (pixels)
	);

	// stage 4: byte order, result register and strobe
	mcu_pack u_pack (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pixels),
		.layout (pixel_layout_q),
		.done   (done),
		.result (result)
	);

	// every accepted item comes out on done once it has passed all the stages
	`MCU_ASSERT_DLY(a_latency, accept, 4, done)
	// a result always holds one or two pixels
	`MCU_ASSERT_IMP(a_count, done, result.pixel_count == 2'd1 || result.pixel_count == 2'd2)
	// a lone pixel leaves the second pixel's bytes clear
	`MCU_ASSERT_IMP(a_single_zero, done && result.pixel_count == 2'd1,
		result.second_byte0 == 8'd0 && result.second_byte3 == 8'd0)
	// before any layout write the bytes come out as rgb with byte 3 clear
	`MCU_ASSERT_IMP(a_reset_layout, done && !layout_q, result.first_byte3 == 8'd0)

endmodule

[test/tb_top.sv]
// Self-checking testbench for merged_chroma_upsample_ycc_to_rgb.
// Depends on mcu_pkg and the RTL; it predicts every packed pixel pair and
// checks each done strobe against it.
`timescale 1ns / 1ps

module tb_top;
	import mcu_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;  // generous cap on the whole run
	localparam int DRAIN_CYCLES = 16;      // pipeline is 4 deep; wait well past it
	localparam int PRINT_CAP    = 50;      // stop printing mismatches after this many

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #10 clk = ~clk;

	// DUT inputs, all at known values from time zero
	logic    start     = 1'b0;
	logic    busy;
	item_t   item      = '0;
	logic    cfg_valid = 1'b0;
	logic    cfg_ready;
	logic [2:0] cfg_data = '0;
	logic    done;
	result_t result;

	merged_chroma_upsample_ycc_to_rgb u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

	// testbench state
	item_t      pixel_pairs_q[$];   // items waiting to be driven
	result_t    pixels_due_q[$];    // predicted results, oldest first
	logic [2:0] layout_shadow = LAYOUT_RGB;
	int         error_count   = 0;
	int         cycle_count   = 0;
	int         gap_left      = 0;
	int         gap_pct       = 0;  // chance (percent) of a gap after each item
	bit         gaps_on       = 1'b1;

	// ------------------------------------------------------------------
	// Color math, written independently of the RTL
	// ------------------------------------------------------------------

	function automatic logic [7:0] sat8(int v);
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return 8'd255;
		return v[7:0];
	endfunction

	// One pixel in the selected byte order, byte 0 in the top bits.
	// Reserved codes fall through to plain rgb.
	function automatic logic [31:0] pack_px(int y, int tr, int tg, int tb, logic [2:0] layout);
		logic [7:0] red;
		logic [7:0] grn;
		logic [7:0] blu;
		red = sat8(y + tr);
		grn = sat8(y + tg);
		blu = sat8(y + tb);
		case (layout)
			LAYOUT_BGR:  return {blu, grn, red, 8'h00};
			LAYOUT_RGBX: return {red, grn, blu, ALPHA_BYTE};
			LAYOUT_XRGB: return {ALPHA_BYTE, red, grn, blu};
			LAYOUT_BGRX: return {blu, grn, red, ALPHA_BYTE};
			LAYOUT_XBGR: return {ALPHA_BYTE, blu, grn, red};
			default:     return {red, grn, blu, 8'h00};
		endcase
	endfunction

	// Chroma terms are Q16 products, rounded half up; >>> floors on negatives.
	function automatic result_t predict_pixels(item_t it, logic [2:0] layout);
		int cb;
		int cr;
		int tr;
		int tg;
		int tb;
		logic [31:0] px0;
		logic [31:0] px1;
		logic [1:0]  cnt;
		cb  = int'(it.chroma_blue) - 128;
		cr  = int'(it.chroma_red) - 128;
		tr  = (91881 * cr + 32768) >>> 16;
		tg  = (-22554 * cb - 46802 * cr + 32768) >>> 16;
		tb  = (116130 * cb + 32768) >>> 16;
		px0 = pack_px(int'(it.luma_even), tr, tg, tb, layout);
		if (it.single) begin
			// lone pixel at an odd row end: second pixel all zero
			px1 = '0;
			cnt = 2'd1;
		end else begin
			px1 = pack_px(int'(it.luma_odd), tr, tg, tb, layout);
			cnt = 2'd2;
		end
		return result_t'({px0, px1, cnt});
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic item_t mk_item(int y0, int y1, int cb, int cr, bit one);
		item_t it;
		it.luma_even   = y0[7:0];
		it.luma_odd    = y1[7:0];
		it.chroma_blue = cb[7:0];
		it.chroma_red  = cr[7:0];
		it.single      = one;
		return it;
	endfunction

	// Leans on the corners where clamping kicks in, but mostly uniform.
	function automatic logic [7:0] rand_byte();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd128;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic item_t rand_item();
		return mk_item(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
			$urandom_range(3) == 0);
	endfunction

	task automatic add_random(int n);
		repeat (n) pixel_pairs_q.push_back(rand_item());
	endtask

	// Corner items repeated in every layout.
	task automatic add_layout_corners();
		pixel_pairs_q.push_back(mk_item(255, 0, 0, 255, 0));
		pixel_pairs_q.push_back(mk_item(0, 255, 255, 0, 0));
		pixel_pairs_q.push_back(mk_item(128, 200, 128, 128, 1));
		pixel_pairs_q.push_back(mk_item(64, 192, 10, 245, 0));
	endtask

	// Mostly bursty, sometimes a clean back-to-back stretch.
	task automatic pick_gap_rate();
		gap_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 40);
	endtask

	// Block until nothing is queued, nothing on the bus, nothing in flight.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pixel_pairs_q.size() != 0 || start || pixels_due_q.size() != 0);
	endtask

	// One config transfer; only called while idle.
	task automatic write_layout(logic [2:0] code);
		cfg_valid <= 1'b1;
		cfg_data  <= code;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid     <= 1'b0;
		layout_shadow = code;
	endtask

	task automatic report_mismatch(string msg);
		error_count++;
		if (error_count <= PRINT_CAP)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	task automatic check_pixels(result_t got, result_t want);
		logic [65:0] g;
		logic [65:0] w;
		string byte_names[8] = '{"first_byte0", "first_byte1", "first_byte2", "first_byte3",
			"second_byte0", "second_byte1", "second_byte2", "second_byte3"};
		g = got;
		w = want;
		for (int i = 0; i < 8; i++) begin
			if (g[65-8*i -: 8] !== w[65-8*i -: 8])
				report_mismatch($sformatf("%s got %0h expected %0h",
					byte_names[i], g[65-8*i -: 8], w[65-8*i -: 8]));
		end
		if (got.pixel_count !== want.pixel_count)
			report_mismatch($sformatf("pixel_count got %0d expected %0d",
				got.pixel_count, want.pixel_count));
	endtask

	// ------------------------------------------------------------------
	// Driver: presents queued items, with random gaps after a transfer.
	// The prediction is taken at the edge where the transfer happens, with
	// the layout in force then (config only changes while idle).
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				pixels_due_q.push_back(predict_pixels(item, layout_shadow));
			// hold the item while busy; otherwise choose what goes next
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pixel_pairs_q.size() > 0) begin
					item  <= pixel_pairs_q.pop_front();
					start <= 1'b1;
					if (gaps_on && $urandom_range(99) < gap_pct)
						gap_left = $urandom_range(1, 14);
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: every done strobe must match the oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pixels_due_q.size() == 0)
				report_mismatch("result arrived with nothing outstanding");
			else
				check_pixels(result, pixels_due_q.pop_front());
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence: reset, directed corners at the reset layout, then one phase
	// per layout code (reserved 6 and 7 included), then random layouts.
	// Each phase drains fully before the layout changes, which also gives
	// the required pause-until-empty on the sender side.
	// ------------------------------------------------------------------
	initial begin
		logic [2:0] layout_order[8] = '{LAYOUT_XBGR, LAYOUT_BGR, LAYOUT_RGBX, LAYOUT_XRGB,
			LAYOUT_BGRX, 3'd6, 3'd7, LAYOUT_RGB};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset layout is rgb; no write yet
		pick_gap_rate();
		pixel_pairs_q.push_back(mk_item(0, 0, 0, 0, 0));
		pixel_pairs_q.push_back(mk_item(255, 255, 255, 255, 0));
		pixel_pairs_q.push_back(mk_item(0, 255, 128, 128, 0));    // neutral chroma
		pixel_pairs_q.push_back(mk_item(255, 0, 128, 128, 0));
		pixel_pairs_q.push_back(mk_item(0, 0, 0, 255, 0));        // max red, min blue
		pixel_pairs_q.push_back(mk_item(255, 255, 255, 0, 0));    // max blue, min red
		pixel_pairs_q.push_back(mk_item(128, 128, 0, 255, 0));
		pixel_pairs_q.push_back(mk_item(128, 128, 255, 0, 0));
		pixel_pairs_q.push_back(mk_item(16, 235, 0, 0, 0));
		pixel_pairs_q.push_back(mk_item(235, 16, 255, 255, 0));
		pixel_pairs_q.push_back(mk_item(200, 77, 90, 240, 1));    // single, odd luma ignored
		pixel_pairs_q.push_back(mk_item(255, 255, 255, 255, 1));
		pixel_pairs_q.push_back(mk_item(0, 255, 0, 0, 1));
		pixel_pairs_q.push_back(mk_item(1, 254, 127, 129, 0));   // rounding near zero
		add_random(60);
		wait_idle();

		foreach (layout_order[i]) begin
			write_layout(layout_order[i]);
			pick_gap_rate();
			add_layout_corners();
			add_random(100);
			wait_idle();
		end

		for (int p = 0; p < 6; p++) begin
			write_layout(3'($urandom_range(7)));
			pick_gap_rate();
			if (p == 5)
				gaps_on = 1'b0;   // closing stretch runs back to back
			add_random(100);
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pixels_due_q.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				pixels_due_q.size()));

		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
